// ===== rtl/core/sst_pkg.sv =====
// Package for the sorted schedule table interpolator.
// Holds field widths, request and sequencer codes and timing constants.
// No dependencies.
package sst_pkg;

   localparam int KEY_W  = 24;
   localparam int VAL_W  = 16;
   localparam int EFF_W  = 8;
   localparam int REC_W  = KEY_W + VAL_W + EFF_W;
   localparam int NOW_W  = 17;
   localparam int TIME_W = 18;
   localparam int NUM_W  = 33;
   localparam int DEN_W  = 18;

   localparam logic [7:0]        FIELD_EMPTY  = 8'hFF;
   localparam logic [TIME_W-1:0] SLOT_SECONDS = 18'd900;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_LOOKUP = 2'd2,
      REQ_NONE   = 2'd3
   } req_type_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_INS_RD,
      ST_INS_WR,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WT,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/core/sorted_schedule_table_interpolator.sv =====
// Top level of the sorted schedule table interpolator: sequencer and datapath.
// Depends on sst_pkg, sst_ram (point storage) and sst_div (interpolation divide).
//
//  channel | ports                                   | direction
//  req     | req_valid/req_ready, key, value, time   | in
//  rsp     | rsp_valid/rsp_ready, ok, level, count   | out
//  csr     | csr_valid/csr_ready, csr_max_pwm        | in
//
// Each entry visited is read through the single RAM read port: the scan walks
// the entries in key order, an insert shifts the entries from pos up, and a
// delete shifts the entries above pos down; a lookup then adds a multiply
// step, a divider start step and a wait on the divider.
// Reset empties the table at once through the fill count; no clearing pass.
// req_ready is low while an item is in work; a pending rsp transfer stalls only
// the final cycle of the next item.
module sorted_schedule_table_interpolator #(
   parameter int ENTRIES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_module_id,
   input  logic [7:0]  req_channel_id,
   input  logic [7:0]  req_slot_index,
   input  logic [15:0] req_point_value,
   input  logic [7:0]  req_effect_code,
   input  logic [16:0] req_time_of_day,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [15:0] rsp_level,
   output logic [7:0]  rsp_used_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_pwm
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);
   localparam int TW = sst_pkg::TIME_W;
   localparam int RW = sst_pkg::REC_W;

   sst_pkg::state_type    state_ff, state_in;
   sst_pkg::req_type_type op_ff, op_in;
   logic [23:0]   key_ff, key_in;
   logic [15:0]   val_ff, val_in;
   logic [7:0]    eff_ff, eff_in;
   logic [16:0]   now_ff, now_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [TW-1:0] ts_ff, ts_in, te_ff, te_in;
   logic [15:0]   vs_ff, vs_in, ve_ff, ve_in;
   logic [32:0]   num_ff, num_in;
   logic [17:0]   den_ff, den_in;
   logic          neg_ff, neg_in;
   logic          ok_ff, ok_in;
   logic [15:0]   level_ff, level_in;
   logic [15:0]   max_pwm_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [15:0]   rsp_level_ff, rsp_level_in;
   logic [7:0]    rsp_used_ff, rsp_used_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [RW-1:0] wr_data, rd_data;
   logic [23:0]   rd_key;
   logic [15:0]   rd_val;
   logic [TW-1:0] slot_time, now_ext;
   logic [CW:0]   idx_plus;
   logic [16:0]   diff;
   logic [15:0]   dv_mag, q16, r16;
   logic          div_done;
   logic [32:0]   quotient;
   logic          key_bad;

   sst_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == sst_pkg::ST_DIV_GO),
      .dividend (num_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rd_key    = rd_data[RW-1 -: 24];
   assign rd_val    = rd_data[23:8];
   assign slot_time = TW'(rd_key[7:0]) * sst_pkg::SLOT_SECONDS;
   assign now_ext   = TW'(now_ff);
   assign idx_plus  = {1'b0, idx_ff} + 1'b1;
   assign key_bad   = (req_module_id == sst_pkg::FIELD_EMPTY)
                    || (req_channel_id == sst_pkg::FIELD_EMPTY)
                    || (req_slot_index == sst_pkg::FIELD_EMPTY);
   assign diff      = 17'(now_ext - ts_ff);
   assign dv_mag    = (ve_ff >= vs_ff) ? (ve_ff - vs_ff) : (vs_ff - ve_ff);
   assign q16       = neg_ff ? (~quotient[15:0] + 16'd1) : quotient[15:0];
   assign r16       = q16 + vs_ff;

   // sequencer: next state, table writes and result
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      eff_in   = eff_ff;
      now_in   = now_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      ts_in    = ts_ff;
      te_in    = te_ff;
      vs_in    = vs_ff;
      ve_in    = ve_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      ok_in    = ok_ff;
      level_in = level_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[IW-1:0];
      wr_data  = rd_data;
      rd_addr  = idx_ff[IW-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_level_in = rsp_level_ff;
      rsp_used_in  = rsp_used_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         sst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = sst_pkg::req_type_type'(req_type);
               key_in   = {req_module_id, req_channel_id, req_slot_index};
               val_in   = req_point_value;
               eff_in   = req_effect_code;
               now_in   = req_time_of_day;
               idx_in   = '0;
               ts_in    = '0;
               te_in    = '0;
               vs_in    = '0;
               ve_in    = '0;
               ok_in    = 1'b0;
               level_in = '0;
               if ((sst_pkg::req_type_type'(req_type) == sst_pkg::REQ_NONE)
                   || ((sst_pkg::req_type_type'(req_type) == sst_pkg::REQ_INSERT)
                       && key_bad)) begin
                  state_in = sst_pkg::ST_FINISH;
               end else begin
                  state_in = sst_pkg::ST_SCAN_RD;
               end
            end
         end

         // issue the read of the next entry, or handle the end of the table
         sst_pkg::ST_SCAN_RD: begin
            if (idx_ff < count_ff) begin
               state_in = sst_pkg::ST_SCAN_CHK;
            end else begin
               case (op_ff)
                  sst_pkg::REQ_INSERT: begin
                     if (count_ff == FULL) begin
                        state_in = sst_pkg::ST_FINISH;
                     end else begin
                        pos_in   = count_ff;
                        state_in = sst_pkg::ST_INS_RD;
                     end
                  end
                  sst_pkg::REQ_LOOKUP: state_in = sst_pkg::ST_MUL;
                  default:             state_in = sst_pkg::ST_FINISH;
               endcase
            end
         end

         sst_pkg::ST_SCAN_CHK: begin
            idx_in   = CW'(idx_plus);
            state_in = sst_pkg::ST_SCAN_RD;
            case (op_ff)
               sst_pkg::REQ_INSERT: begin
                  if (rd_key == key_ff) begin
                     wr_en    = 1'b1;
                     wr_data  = {key_ff, val_ff, eff_ff};
                     ok_in    = 1'b1;
                     state_in = sst_pkg::ST_FINISH;
                  end else if (rd_key > key_ff) begin
                     // refuse a new key when the table is full
                     if (count_ff == FULL) begin
                        state_in = sst_pkg::ST_FINISH;
                     end else begin
                        pos_in   = idx_ff;
                        idx_in   = count_ff;
                        state_in = sst_pkg::ST_INS_RD;
                     end
                  end
               end
               sst_pkg::REQ_DELETE: begin
                  if (rd_key == key_ff) begin
                     idx_in   = idx_ff;
                     state_in = sst_pkg::ST_DEL_RD;
                  end
               end
               default: begin
                  if (rd_key[23:8] == key_ff[23:8]) begin
                     if (now_ext >= slot_time) begin
                        ts_in = slot_time;
                        vs_in = rd_val;
                     end
                     if (now_ext <= slot_time) begin
                        te_in    = slot_time;
                        ve_in    = rd_val;
                        state_in = sst_pkg::ST_MUL;
                     end
                  end
               end
            endcase
         end

         // shift entries up from the top to open the slot at pos
         sst_pkg::ST_INS_RD: begin
            rd_addr = IW'(idx_ff - 1'b1);
            if (idx_ff > pos_ff) begin
               state_in = sst_pkg::ST_INS_WR;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[IW-1:0];
               wr_data  = {key_ff, val_ff, eff_ff};
               count_in = count_ff + 1'b1;
               ok_in    = 1'b1;
               state_in = sst_pkg::ST_FINISH;
            end
         end

         sst_pkg::ST_INS_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - 1'b1;
            state_in = sst_pkg::ST_INS_RD;
         end

         // shift entries down over the deleted one
         sst_pkg::ST_DEL_RD: begin
            rd_addr = IW'(idx_plus);
            if (idx_plus < {1'b0, count_ff}) begin
               state_in = sst_pkg::ST_DEL_WR;
            end else begin
               count_in = count_ff - 1'b1;
               ok_in    = 1'b1;
               state_in = sst_pkg::ST_FINISH;
            end
         end

         sst_pkg::ST_DEL_WR: begin
            wr_en    = 1'b1;
            idx_in   = CW'(idx_plus);
            state_in = sst_pkg::ST_DEL_RD;
         end

         // form numerator and denominator magnitudes and the sign, or take the start value when both ends coincide
         sst_pkg::ST_MUL: begin
            ok_in = 1'b1;
            if (ts_ff == te_ff) begin
               level_in = vs_ff;
               state_in = sst_pkg::ST_FINISH;
            end else begin
               num_in   = 33'(diff) * 33'(dv_mag);
               den_in   = (te_ff >= ts_ff) ? (te_ff - ts_ff) : (ts_ff - te_ff);
               neg_in   = (ve_ff < vs_ff) ^ (te_ff < ts_ff);
               state_in = sst_pkg::ST_DIV_GO;
            end
         end

         sst_pkg::ST_DIV_GO: state_in = sst_pkg::ST_DIV_WT;

         // apply sign, add start value, clamp
         sst_pkg::ST_DIV_WT: begin
            if (div_done) begin
               level_in = (r16 > max_pwm_ff) ? max_pwm_ff : r16;
               state_in = sst_pkg::ST_FINISH;
            end
         end

         // hold until the output register is free, then load it
         sst_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_level_in = level_ff;
               rsp_used_in  = 8'(count_ff);
               state_in     = sst_pkg::ST_IDLE;
            end
         end

         default: state_in = sst_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         max_pwm_ff   <= 16'd4095;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            max_pwm_ff <= csr_max_pwm;
         end
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      eff_ff       <= eff_in;
      now_ff       <= now_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      ts_ff        <= ts_in;
      te_ff        <= te_in;
      vs_ff        <= vs_in;
      ve_ff        <= ve_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      neg_ff       <= neg_in;
      ok_ff        <= ok_in;
      level_ff     <= level_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_level_ff <= rsp_level_in;
      rsp_used_ff  <= rsp_used_in;
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_used_count = rsp_used_ff;

endmodule

// ===== rtl/core/sst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sst_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sst_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sst_pkg for operand widths.
module sst_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [sst_pkg::NUM_W-1:0] dividend,
   input  logic [sst_pkg::DEN_W-1:0] divisor,
   output logic                     done,
   output logic [sst_pkg::NUM_W-1:0] quotient
);

   localparam int NW = sst_pkg::NUM_W;
   localparam int DW = sst_pkg::DEN_W;
   localparam int SW = $clog2(NW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] div_ff, div_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic          fits;

   // one shift and trial subtract a cycle
   always_comb begin
      trial    = {rem_ff, quo_ff[NW-1]};
      fits     = trial >= {1'b0, div_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      steps_in = steps_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
         steps_in = SW'(NW);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? DW'(trial - {1'b0, div_ff}) : trial[DW-1:0];
         quo_in   = {quo_ff[NW-2:0], fits};
         steps_in = steps_ff - 1'b1;
         if (steps_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      steps_ff <= steps_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
